### rtl/mrlc_pkg.sv
// Shared types, codes and character constants for the modem response line classifier.
package mrlc_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  // Item operations
  localparam logic [1:0] OP_BYTE      = 2'd0;
  localparam logic [1:0] OP_CLR_STAGE = 2'd1;
  localparam logic [1:0] OP_CLR_RING  = 2'd2;

  // Capture stages
  localparam logic [1:0] STG_SCAN   = 2'd0;
  localparam logic [1:0] STG_HEADER = 2'd1;
  localparam logic [1:0] STG_BODY   = 2'd2;
  localparam logic [1:0] STG_DONE   = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_U    = 8'h55;

  typedef enum logic [3:0] {
    EV_STORED  = 4'd0,
    EV_DROPPED = 4'd1,
    EV_CR      = 4'd2,
    EV_PROMPT  = 4'd3,
    EV_OK      = 4'd4,
    EV_PLAIN   = 4'd5,
    EV_HEADER  = 4'd6,
    EV_BODY    = 4'd7,
    EV_IGNORED = 4'd8
  } mrlc_event_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic       balance_query_pending;
  } mrlc_in_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [6:0] line_length;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       new_sms_notice;
    logic       balance_reply;
    logic       ring_alert;
    logic [1:0] stage_now;
  } mrlc_out_t;

endpackage

### rtl/modem_response_line_classifier_top.sv
// Top level of the modem response line classifier.
//
// Input channel in_valid/in_ready/in_data carries one item: a received byte or
// a command (clear capture stage, clear ring flag). Every item yields exactly
// one result on out_valid/out_ready/out_data, in order.
// Bytes other than CR and '>' are written into the line store at the current
// fill while it has room. A line feed after a carriage return ends a non-empty
// line; the store is then read back one entry per cycle, a four-byte window
// looks for the notice, balance and ring patterns, and the first three bytes
// are checked for OK. A byte or command item is handled in the execute state;
// a line-end item walks the store in the scan state (fill up to LINE_DEPTH)
// plus the three trailing window slots, then loads its result in the finish
// state. One item is in work at a time; the next transfer is taken the cycle
// after a result is loaded into the output register, even while that result
// waits. When the receiver stalls with a result pending, the block takes the
// next item and holds it in the execute state until the output register frees.
// Reset clears fill count, flags and stage; store contents stay undefined and
// need no clearing pass, as entries at or past the fill read as zero.
module modem_response_line_classifier_top #(
  parameter int LINE_DEPTH = mrlc_pkg::LINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrlc_pkg::mrlc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrlc_pkg::mrlc_out_t out_data
);
  import mrlc_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  mrlc_store #(.LINE_DEPTH(LINE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mrlc_ctrl #(.LINE_DEPTH(LINE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

### rtl/mrlc_store.sv
// Line store: single-port-write, single-port-read memory with registered read data.
module mrlc_store #(
  parameter int LINE_DEPTH = mrlc_pkg::LINE_DEPTH_DEF,
  localparam int AW = $clog2(LINE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  import mrlc_pkg::*;

  logic [7:0] mem [LINE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/mrlc_ctrl.sv
// Sequencer: byte handling, line-end scan over the store, result register.
module mrlc_ctrl #(
  parameter int LINE_DEPTH = mrlc_pkg::LINE_DEPTH_DEF,
  localparam int AW = $clog2(LINE_DEPTH),
  localparam int CW = $clog2(LINE_DEPTH + 1),
  localparam int PW = CW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrlc_pkg::mrlc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrlc_pkg::mrlc_out_t out_data,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [7:0]          mem_rdata
);
  import mrlc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_FIN} state_t;

  state_t      state_r;
  mrlc_in_t    item_r;
  logic [CW-1:0] count_r;
  logic        cr_seen_r;
  logic [1:0]  stage_r;
  logic        ring_seen_r;
  logic [PW-1:0] pos_r;
  logic [7:0]  b1_r, b2_r, b3_r;
  logic [7:0]  c0_r, c1_r, c2_r;
  logic        ring_tmp_r, sms_r, bal_r, alert_r;
  logic        out_valid_r;
  mrlc_out_t   out_data_r;

  logic        out_free, line_end, store_ok;
  logic        out_load, out_valid_nxt;
  logic [PW-1:0] count_ext, pos_plus1;
  logic        in_line, eval_en, scan_done;
  logic [7:0]  scan_b;
  logic        hit_plus, hit_mt, hit_us, hit_cl, is_ok;

  mrlc_event_t exec_ev, fin_ev;
  mrlc_out_t   exec_res, fin_res;
  logic [CW-1:0] exec_count;
  logic [1:0]  exec_stage, fin_stage;
  logic        exec_ring, exec_cr, fin_ring;

  assign out_free  = !out_valid_r || out_ready;
  assign line_end  = (item_r.op == OP_BYTE) && (item_r.rx_byte == CH_LF) && cr_seen_r &&
                     (count_r != '0);
  assign store_ok  = count_r < CW'(LINE_DEPTH);
  assign count_ext = PW'(count_r);
  assign pos_plus1 = pos_r + PW'(1);

  // Load the output register from a single-step item or a finished scan
  assign out_load      = out_free && (((state_r == ST_EXEC) && !line_end) ||
                                      (state_r == ST_FIN));
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  // Positions at or past the fill read as zero
  assign in_line   = pos_r < count_ext;
  assign scan_b    = in_line ? mem_rdata : 8'h00;
  assign eval_en   = (pos_r >= PW'(3)) && ((pos_r - PW'(3)) < count_ext);
  assign scan_done = pos_r == (count_ext + PW'(2));

  // Window: b3 = at(p), b2 = at(p+1), b1 = at(p+2), scan_b = at(p+3)
  assign hit_plus = eval_en && (b3_r == CH_PLUS);
  assign hit_mt   = (b1_r == CH_M) && (scan_b == CH_T);
  assign hit_us   = (b1_r == CH_U) && (scan_b == CH_S);
  assign hit_cl   = (b2_r == CH_C) && (b1_r == CH_L);

  assign is_ok = ((c0_r == CH_O) && (c1_r == CH_K)) || ((c1_r == CH_O) && (c2_r == CH_K));

  assign mem_we    = (state_r == ST_EXEC) && out_free && (item_r.op == OP_BYTE) && !line_end &&
                     (item_r.rx_byte != CH_CR) && (item_r.rx_byte != CH_GT) && store_ok;
  assign mem_waddr = count_r[AW-1:0];
  assign mem_wdata = item_r.rx_byte;
  assign mem_raddr = (state_r == ST_SCAN) ? pos_plus1[AW-1:0] : '0;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Single-step items
  always_comb begin
    exec_ev    = EV_STORED;
    exec_count = count_r;
    exec_stage = stage_r;
    exec_ring  = ring_seen_r;
    exec_cr    = cr_seen_r;
    case (item_r.op)
      OP_BYTE: begin
        if (item_r.rx_byte == CH_CR) begin
          exec_cr = 1'b1;
          exec_ev = EV_CR;
        end else if (item_r.rx_byte == CH_GT) begin
          exec_ev = EV_PROMPT;
        end else if (store_ok) begin
          exec_count = count_r + CW'(1);
          exec_ev    = EV_STORED;
        end else begin
          exec_ev = EV_DROPPED;
        end
      end
      OP_CLR_STAGE: exec_stage = STG_SCAN;
      OP_CLR_RING:  exec_ring  = 1'b0;
      default: ;
    endcase
    exec_res             = '0;
    exec_res.event_res   = exec_ev;
    exec_res.line_length = 7'(exec_count);
    exec_res.stage_now   = exec_stage;
  end

  // Line-end classification
  always_comb begin
    fin_res   = '0;
    fin_stage = stage_r;
    fin_ring  = ring_seen_r;
    fin_ev    = EV_OK;
    if (!is_ok) begin
      case (stage_r)
        STG_SCAN: begin
          fin_ev                 = EV_PLAIN;
          fin_res.new_sms_notice = sms_r;
          fin_res.balance_reply  = bal_r;
          fin_res.ring_alert     = alert_r;
          fin_ring               = ring_tmp_r;
          fin_stage              = sms_r ? STG_HEADER : STG_SCAN;
        end
        STG_HEADER: begin
          fin_ev    = EV_HEADER;
          fin_stage = STG_BODY;
        end
        STG_BODY: begin
          fin_ev    = EV_BODY;
          fin_stage = STG_DONE;
        end
        default: fin_ev = EV_IGNORED;
      endcase
    end
    fin_res.event_res   = fin_ev;
    fin_res.line_length = 7'(count_r);
    fin_res.first_char  = c0_r;
    fin_res.second_char = c1_r;
    fin_res.stage_now   = fin_stage;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cr_seen_r   <= 1'b0;
      stage_r     <= STG_SCAN;
      ring_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            if (line_end) begin
              pos_r      <= '0;
              ring_tmp_r <= ring_seen_r;
              sms_r      <= 1'b0;
              bal_r      <= 1'b0;
              alert_r    <= 1'b0;
              state_r    <= ST_SCAN;
            end else begin
              count_r     <= exec_count;
              stage_r     <= exec_stage;
              ring_seen_r <= exec_ring;
              cr_seen_r   <= exec_cr;
              out_data_r  <= exec_res;
              state_r     <= ST_IDLE;
            end
          end
        end
        ST_SCAN: begin
          if (pos_r == PW'(0)) c0_r <= scan_b;
          if (pos_r == PW'(1)) c1_r <= scan_b;
          if (pos_r == PW'(2)) c2_r <= scan_b;
          b1_r <= scan_b;
          b2_r <= b1_r;
          b3_r <= b2_r;
          if (hit_plus) begin
            if (hit_mt) sms_r <= 1'b1;
            if (hit_us && item_r.balance_query_pending) bal_r <= 1'b1;
            // First ring arms, later rings alert
            if (hit_cl) begin
              if (ring_tmp_r) alert_r <= 1'b1;
              else ring_tmp_r <= 1'b1;
            end
          end
          if (scan_done) state_r <= ST_FIN;
          else pos_r <= pos_plus1;
        end
        ST_FIN: begin
          if (out_free) begin
            stage_r     <= fin_stage;
            ring_seen_r <= fin_ring;
            count_r     <= '0;
            out_data_r  <= fin_res;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/mrlc_checker.sv
// Port-level checker for the modem response line classifier, bound to the top.
module mrlc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mrlc_pkg::mrlc_out_t out_data
);
  import mrlc_pkg::*;

  // No result comes out of reset, and the input side is open
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("result valid right after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Non-line results carry no characters or flags
  a_noline_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == EV_STORED || out_data.event_res == EV_DROPPED ||
                  out_data.event_res == EV_CR || out_data.event_res == EV_PROMPT)
    |-> out_data.first_char == 8'h00 && out_data.second_char == 8'h00 &&
        !out_data.new_sms_notice && !out_data.balance_reply && !out_data.ring_alert)
    else $error("non-line result carries line fields");

  // Pattern flags only come from a plain line scan
  a_flags_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.new_sms_notice || out_data.balance_reply || out_data.ring_alert)
    |-> out_data.event_res == EV_PLAIN)
    else $error("pattern flag on a non-plain result");

  // A notice moves capture to the header stage
  a_sms_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_sms_notice |-> out_data.stage_now == STG_HEADER)
    else $error("notice without stage advance");

endmodule

bind modem_response_line_classifier_top mrlc_checker u_mrlc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for the modem response line classifier: directed and random byte streams.
module testbench;
  import mrlc_pkg::*;

  localparam int          DEPTH      = LINE_DEPTH_DEF;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          SETTLE     = DEPTH + 16;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          RAND_ITEMS = 230;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mrlc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mrlc_out_t out_data;

  // Own copy of the classifier state
  logic [7:0] pm_store [DEPTH];
  int         pm_fill = 0;
  logic       pm_cr = 1'b0;
  logic [1:0] pm_stage = STG_SCAN;
  logic       pm_ring = 1'b0;

  mrlc_out_t classified_q [$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;

  modem_response_line_classifier_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [7:0] line_at(int p);
    return (p < pm_fill && p < DEPTH) ? pm_store[p] : 8'h00;
  endfunction

  // Advance the line state by one item and return the result it produces.
  function automatic mrlc_out_t classify_item(mrlc_in_t it);
    mrlc_out_t r;
    logic [7:0] c0;
    logic [7:0] c1;
    r = '0;
    r.line_length = '0;
    case (it.op)
      OP_CLR_STAGE: pm_stage = STG_SCAN;
      OP_CLR_RING:  pm_ring = 1'b0;
      OP_BYTE: begin
        if (it.rx_byte == CH_LF && pm_cr && pm_fill > 0) begin
          c0 = line_at(0);
          c1 = line_at(1);
          r.first_char  = c0;
          r.second_char = c1;
          if ((c0 == CH_O && c1 == CH_K) || (c1 == CH_O && line_at(2) == CH_K)) begin
            r.event_res = EV_OK;
          end else if (pm_stage == STG_SCAN) begin
            r.event_res = EV_PLAIN;
            for (int p = 0; p < pm_fill; p++) begin
              if (line_at(p) == CH_PLUS) begin
                if (line_at(p + 2) == CH_M && line_at(p + 3) == CH_T) begin
                  pm_stage = STG_HEADER;
                  r.new_sms_notice = 1'b1;
                end
                if (line_at(p + 2) == CH_U && line_at(p + 3) == CH_S &&
                    it.balance_query_pending)
                  r.balance_reply = 1'b1;
                if (line_at(p + 1) == CH_C && line_at(p + 2) == CH_L) begin
                  if (pm_ring) r.ring_alert = 1'b1;
                  else pm_ring = 1'b1;
                end
              end
            end
          end else if (pm_stage == STG_HEADER) begin
            r.event_res = EV_HEADER;
            pm_stage = STG_BODY;
          end else if (pm_stage == STG_BODY) begin
            r.event_res = EV_BODY;
            pm_stage = STG_DONE;
          end else begin
            r.event_res = EV_IGNORED;
          end
          r.line_length = pm_fill[6:0];
          pm_fill = 0;
        end else begin
          if (it.rx_byte == CH_CR) begin
            pm_cr = 1'b1;
            r.event_res = EV_CR;
          end else if (it.rx_byte == CH_GT) begin
            r.event_res = EV_PROMPT;
          end else if (pm_fill < DEPTH) begin
            pm_store[pm_fill] = it.rx_byte;
            pm_fill++;
            r.event_res = EV_STORED;
          end else begin
            r.event_res = EV_DROPPED;
          end
          r.line_length = pm_fill[6:0];
        end
      end
      default: ;
    endcase
    if (it.op != OP_BYTE) r.line_length = pm_fill[6:0];
    r.stage_now = pm_stage;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    mrlc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (classified_q.size() == 0) begin
        report_mismatch("unexpected result", out_data, '0);
      end else begin
        want = classified_q.pop_front();
        check_field("event_res", 32'(out_data.event_res), 32'(want.event_res));
        check_field("line_length", 32'(out_data.line_length), 32'(want.line_length));
        check_field("first_char", 32'(out_data.first_char), 32'(want.first_char));
        check_field("second_char", 32'(out_data.second_char), 32'(want.second_char));
        check_field("new_sms_notice", 32'(out_data.new_sms_notice),
                    32'(want.new_sms_notice));
        check_field("balance_reply", 32'(out_data.balance_reply), 32'(want.balance_reply));
        check_field("ring_alert", 32'(out_data.ring_alert), 32'(want.ring_alert));
        check_field("stage_now", 32'(out_data.stage_now), 32'(want.stage_now));
      end
    end
  end

  // Receiver: stall a random number of cycles before each result.
  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Valid stays up after a transfer; the next call either replaces the payload
  // in the same step or drops valid for its gap.
  task automatic send_item(input mrlc_in_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    classified_q.push_back(classify_item(item));
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit pend);
    mrlc_in_t it;
    it.op = OP_BYTE;
    it.rx_byte = b;
    it.balance_query_pending = pend;
    send_item(it);
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] b, input bit pend);
    mrlc_in_t it;
    it.op = op;
    it.rx_byte = b;
    it.balance_query_pending = pend;
    send_item(it);
  endtask

  task automatic send_text(input string s, input bit pend);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], pend);
  endtask

  task automatic send_line(input string s, input bit pend);
    send_text(s, pend);
    send_byte(CH_CR, pend);
    send_byte(CH_LF, pend);
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_all_results();
    hold_input();
    while (classified_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Byte extremes, a line feed before any carriage return, prompt, commands.
  task automatic test_raw_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_GT, 1'b1);
    send_cmd(OP_UNUSED, 8'hFF, 1'b1);
    send_cmd(OP_CLR_STAGE, 8'h00, 1'b0);
    send_cmd(OP_CLR_RING, 8'hAA, 1'b1);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    // line feed on an empty line is stored, then ends its own line
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    wait_all_results();
  endtask

  task automatic test_ok_lines();
    send_line("OK", 1'b0);
    send_line(" OK", 1'b1);
    // K left at offset 2 from the line before lies past this line's end
    send_line("xO", 1'b0);
    send_line("O", 1'b0);
    wait_all_results();
  endtask

  task automatic test_sms_capture();
    send_line("+CMT: 1", 1'b0);
    send_line("hdr", 1'b0);
    send_line("body", 1'b1);
    send_line("x", 1'b0);
    send_cmd(OP_CLR_STAGE, 8'h0D, 1'b0);
    // notice matched here; stale M and T past the end of the next, shorter line must not match
    send_line("++MT", 1'b0);
    send_cmd(OP_CLR_STAGE, 8'h00, 1'b0);
    send_line("+a", 1'b0);
    wait_all_results();
  endtask

  task automatic test_balance_ring();
    send_line("+CUSD: 1", 1'b1);
    send_line("+CUSD: 1", 1'b0);
    send_cmd(OP_CLR_RING, 8'h00, 1'b0);
    send_line("+CLIP", 1'b0);
    send_line("+CLIP", 1'b0);
    send_cmd(OP_CLR_RING, 8'h00, 1'b0);
    send_line("+CL+CL", 1'b1);
    wait_all_results();
  endtask

  task automatic test_store_full();
    for (int i = 0; i < DEPTH + 3; i++) send_byte(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    wait_all_results();
  endtask

  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 3))
      0: case ($urandom_range(0, 9))
           0: return CH_PLUS;
           1: return CH_M;
           2: return CH_T;
           3: return CH_U;
           4: return CH_S;
           5: return CH_C;
           6: return CH_L;
           7: return CH_O;
           8: return CH_K;
           default: return CH_PLUS;
         endcase
      3: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_random_line();
    int  n;
    bit  pend;
    string head;
    pend = 1'($urandom_range(0, 1));
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 6)
                                     : $urandom_range(0, 10);
    case ($urandom_range(0, 7))
      0: head = "OK";
      1: head = " OK";
      2: head = "+CMT";
      3: head = "+CUSD";
      4: head = "+CLIP";
      5: head = "+CL";
      6: head = "+xMT";
      default: head = "";
    endcase
    send_text(head, pend);
    for (int i = 0; i < n; i++) send_byte(line_byte(), pend);
    send_byte(CH_CR, pend);
    send_byte(CH_LF, pend);
  endtask

  // Mostly well-formed lines, with commands, noise and broken lines mixed in.
  task automatic test_random_stream();
    int  start;
    int  seq;
    bit  drained;
    start = items_sent;
    seq = 0;
    drained = 1'b0;
    while (items_sent - start < RAND_ITEMS) begin
      if (seq % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
      seq++;
      case ($urandom_range(0, 9))
        7: send_cmd(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        8: repeat ($urandom_range(1, 5))
             send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        9: case ($urandom_range(0, 2))
             0: send_byte(CH_LF, 1'($urandom_range(0, 1)));
             1: repeat ($urandom_range(1, 6)) send_byte(line_byte(), 1'b0);
             default: begin
               send_byte(CH_GT, 1'b0);
               send_text("+CMT", 1'b0);
             end
           endcase
        default: send_random_line();
      endcase
      if (!drained && items_sent - start >= RAND_ITEMS / 2) begin
        drained = 1'b1;
        wait_all_results();
      end
    end
    no_idle = 1'b0;
    wait_all_results();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) pm_store[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_raw_bytes();
    test_ok_lines();
    test_sms_capture();
    test_balance_ring();
    test_store_full();
    test_random_stream();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mrlc_pkg.sv
rtl/mrlc_store.sv
rtl/mrlc_ctrl.sv
rtl/modem_response_line_classifier_top.sv
rtl/mrlc_checker.sv
tb/testbench.sv
